FILE: rtl/core/lap_timer_with_odometer_unit_macros.svh
// Assertion macros shared by the lap timer RTL.
`ifndef LAP_TIMER_WITH_ODOMETER_UNIT_MACROS_SVH
`define LAP_TIMER_WITH_ODOMETER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LTWO_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LTWO_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ltwo_pkg.sv
// Types and constants of the lap timer with odometer.
package ltwo_pkg;

    localparam int LTWO_LAP_DEPTH = 3;
    localparam int LTWO_SLOTS     = 3;

    localparam int LTWO_SEC_W   = 16;
    localparam int LTWO_NUM_W   = 8;
    localparam int LTWO_PULSE_W = 32;
    localparam int LTWO_SPEED_W = 16;
    localparam int LTWO_SUB_W   = 4;
    localparam int LTWO_LOCK_W  = 8;

    localparam int LTWO_DVD_W   = 32;
    localparam int LTWO_DIVR_W  = 21;
    localparam int LTWO_STEP_W  = 6;
    localparam int LTWO_SCALE_W = 22;

    localparam int LTWO_CFG_IDX_W  = 1;
    localparam int LTWO_CFG_DATA_W = 8;
    localparam int LTWO_IN_DATA_W  = 8;
    localparam int LTWO_IN_USER_W  = 2;
    localparam int LTWO_OUT_DATA_W = 136;

    localparam logic [LTWO_CFG_IDX_W-1:0] LTWO_REG_LOCKOUT = 1'd0;
    localparam logic [LTWO_CFG_IDX_W-1:0] LTWO_REG_TPS     = 1'd1;

    localparam logic [1:0] LTWO_REQ_TICK  = 2'd0;
    localparam logic [1:0] LTWO_REQ_LAP   = 2'd1;
    localparam logic [1:0] LTWO_REQ_PULSE = 2'd2;

    localparam logic [LTWO_LOCK_W-1:0] LTWO_LOCKOUT_RESET = 8'd30;
    localparam logic [LTWO_SUB_W-1:0]  LTWO_TPS_RESET     = 4'd10;

    localparam logic [10:0]             LTWO_PULSE_SCALE = 11'd1548;
    localparam logic [4:0]              LTWO_TIME_SCALE  = 5'd20;
    localparam logic [5:0]              LTWO_SPEED_MUL   = 6'd36;
    localparam logic [LTWO_DIVR_W-1:0]  LTWO_SPEED_DIV   = 21'd1000;

    typedef struct packed {
        logic [LTWO_LOCK_W-1:0] lockout_ticks;
        logic [LTWO_SUB_W-1:0]  ticks_per_second;
    } ltwo_cfg_t;

    typedef struct packed {
        logic [LTWO_SEC_W-1:0]                    seconds;
        logic [LTWO_SLOTS-1:0][LTWO_SEC_W-1:0]    lap_time;
        logic [LTWO_SLOTS-1:0][LTWO_NUM_W-1:0]    lap_num;
        logic [LTWO_PULSE_W-1:0]                  pulses;
    } ltwo_view_t;

endpackage

FILE: rtl/core/lap_timer_with_odometer_unit.sv
// Lap timer with odometer: top level with config registers and result register.
//
// Input stream s_axis: one item per event. tuser carries the event kind
// (tick of 0.1 s, lap press, wheel pulse), tdata bit 0 the reset switch level.
// Output stream m_axis: one item per input item with the seconds, the lap
// history, the pulse count and the average speed in 0.1 km/h.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 lockout ticks, 1 ticks per second); write only while the block is idle.
// Order: counters update at acceptance; start_reg then starts the sequencer,
// which runs the bit-serial divider (32 steps for distance over time, 22 steps
// for the km/h scale) and hands the speed to the result register. With zero
// distance or time it skips the divider. One item at a time: s_axis_tready is low while the sequencer works.
// The result register frees the pipe: a new item is taken while the previous
// result waits; if m_axis stalls, the next result holds in the sequencer
// and s_axis_tready stays low until it moves into the result register.
// Reset: lockout 30, ticks per second 10, all counts and laps zero.
module lap_timer_with_odometer_unit #(
    parameter int LAP_DEPTH = ltwo_pkg::LTWO_LAP_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ltwo_pkg::LTWO_CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltwo_pkg::LTWO_CFG_DATA_W-1:0]  cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ltwo_pkg::LTWO_IN_DATA_W-1:0]   s_axis_tdata,  // reset_switch
    input  logic [ltwo_pkg::LTWO_IN_USER_W-1:0]   s_axis_tuser,  // req_type
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // elapsed_sec, lap_time_1..3, lap_num_1..3, distance_pulses, avg_speed
    output logic [ltwo_pkg::LTWO_OUT_DATA_W-1:0]  m_axis_tdata
);
    import ltwo_pkg::*;

    `include "lap_timer_with_odometer_unit_macros.svh"

    ltwo_cfg_t                   cfg_reg;
    logic                        start_reg;
    logic                        out_valid_reg;
    logic [LTWO_OUT_DATA_W-1:0]  out_data_reg;

    logic                        accept;
    logic                        out_load;
    ltwo_view_t                  view;
    logic                        spd_busy;
    logic                        spd_valid;
    logic [LTWO_SPEED_W-1:0]     spd_speed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ticks    <= LTWO_LOCKOUT_RESET;
            cfg_reg.ticks_per_second <= LTWO_TPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                LTWO_REG_LOCKOUT: cfg_reg.lockout_ticks    <= cfg_data;
                LTWO_REG_TPS:     cfg_reg.ticks_per_second <= cfg_data[LTWO_SUB_W-1:0];
                default:          ;
            endcase
        end
    end

    assign s_axis_tready = !spd_busy && !start_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = spd_valid && (!out_valid_reg || m_axis_tready);

    ltwo_state #(
        .LAP_DEPTH (LAP_DEPTH)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .req_type     (s_axis_tuser),
        .reset_switch (s_axis_tdata[0]),
        .cfg          (cfg_reg),
        .view         (view)
    );

    ltwo_speed u_speed (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .ack     (out_load),
        .pulses  (view.pulses),
        .seconds (view.seconds),
        .busy    (spd_busy),
        .valid   (spd_valid),
        .speed   (spd_speed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {spd_speed, view.pulses,
                             view.lap_num[2], view.lap_num[1], view.lap_num[0],
                             view.lap_time[2], view.lap_time[1], view.lap_time[0],
                             view.seconds};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `LTWO_CHECK_NEXT(a_one_item, accept, !s_axis_tready, "item accepted while one is in work")
    `LTWO_CHECK(a_zero_speed, spd_valid && (view.seconds == '0), spd_speed == '0,
        "nonzero speed with zero seconds")
    `LTWO_CHECK(a_lap_count, (LAP_DEPTH > 1) && (view.lap_num[0] != 8'(view.lap_num[1] + 1'b1)),
        (view.lap_num[0] == '0) && (view.lap_num[1] == '0), "lap numbers out of step")

endmodule

FILE: rtl/core/ltwo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ltwo_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ltwo_pkg::LTWO_STEP_W-1:0]   steps,
    input  logic [ltwo_pkg::LTWO_DVD_W-1:0]    dividend,
    input  logic [ltwo_pkg::LTWO_DIVR_W-1:0]   divisor,
    output logic                               done,
    output logic [ltwo_pkg::LTWO_DVD_W-1:0]    quotient
);
    import ltwo_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [LTWO_STEP_W-1:0]  cnt_reg;
    logic [LTWO_DIVR_W-1:0]  rem_reg;
    logic [LTWO_DIVR_W-1:0]  div_reg;
    logic [LTWO_DVD_W-1:0]   dvd_reg;
    logic [LTWO_DVD_W-1:0]   quo_reg;

    logic [LTWO_DIVR_W:0]    trial;
    logic                    fits;
    logic [LTWO_DIVR_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[LTWO_DVD_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? LTWO_DIVR_W'(trial - {1'b0, div_reg}) : trial[LTWO_DIVR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == LTWO_STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            dvd_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[LTWO_DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[LTWO_DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/ltwo_state.sv
// Event state: subsecond and second counters, lockout, lap history, odometer.
module ltwo_state #(
    parameter int LAP_DEPTH = ltwo_pkg::LTWO_LAP_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [ltwo_pkg::LTWO_IN_USER_W-1:0]  req_type,
    input  logic                                 reset_switch,
    input  ltwo_pkg::ltwo_cfg_t                  cfg,
    output ltwo_pkg::ltwo_view_t                 view
);
    import ltwo_pkg::*;

    logic                     running_reg,  running_next;
    logic [LTWO_SEC_W-1:0]    seconds_reg,  seconds_next;
    logic [LTWO_SUB_W-1:0]    sub_reg,      sub_next;
    logic [LTWO_LOCK_W-1:0]   lockout_reg,  lockout_next;
    logic [LTWO_SEC_W-1:0]    mark_reg,     mark_next;
    logic [LTWO_PULSE_W-1:0]  pulses_reg,   pulses_next;
    logic [LTWO_SEC_W-1:0]    times_reg [LAP_DEPTH];
    logic [LTWO_SEC_W-1:0]    times_next [LAP_DEPTH];
    logic [LTWO_NUM_W-1:0]    nums_reg [LAP_DEPTH];
    logic [LTWO_NUM_W-1:0]    nums_next [LAP_DEPTH];

    logic [LTWO_SEC_W-1:0]    time_slot [LTWO_SLOTS];
    logic [LTWO_NUM_W-1:0]    num_slot [LTWO_SLOTS];

    always_comb
    begin
        running_next = running_reg;
        seconds_next = seconds_reg;
        sub_next     = sub_reg;
        lockout_next = lockout_reg;
        mark_next    = mark_reg;
        pulses_next  = pulses_reg;
        times_next   = times_reg;
        nums_next    = nums_reg;

        if (load)
        begin
            unique case (req_type)
                LTWO_REQ_TICK:
                begin
                    if (running_reg)
                        sub_next = sub_reg + 1'b1;
                    else if (sub_reg < cfg.ticks_per_second)
                        sub_next = sub_reg + 1'b1;
                    if (lockout_reg != '0)
                    begin
                        lockout_next = lockout_reg - 1'b1;
                    end
                    else if (reset_switch)
                    begin
                        running_next = 1'b0;
                        seconds_next = '0;
                        mark_next    = '0;
                        pulses_next  = '0;
                        for (int k = 0; k < LAP_DEPTH; k++)
                        begin
                            times_next[k] = '0;
                            nums_next[k]  = '0;
                        end
                    end
                end
                LTWO_REQ_LAP:
                begin
                    lockout_next = cfg.lockout_ticks;
                    if (seconds_reg != mark_reg)
                    begin
                        for (int k = 1; k < LAP_DEPTH; k++)
                        begin
                            times_next[k] = times_reg[k-1];
                            nums_next[k]  = nums_reg[k-1];
                        end
                        times_next[0] = seconds_reg - mark_reg;
                        nums_next[0]  = nums_reg[0] + 1'b1;
                        mark_next     = seconds_reg;
                    end
                end
                LTWO_REQ_PULSE:
                begin
                    running_next = 1'b1;
                    pulses_next  = pulses_reg + 1'b1;
                end
                default:
                begin
                end
            endcase

            // roll a full second
            if (running_next && (sub_next >= cfg.ticks_per_second))
            begin
                seconds_next = seconds_next + 1'b1;
                sub_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            seconds_reg <= '0;
            sub_reg     <= '0;
            lockout_reg <= LTWO_LOCKOUT_RESET;
            mark_reg    <= '0;
            pulses_reg  <= '0;
            for (int k = 0; k < LAP_DEPTH; k++)
            begin
                times_reg[k] <= '0;
                nums_reg[k]  <= '0;
            end
        end
        else
        begin
            running_reg <= running_next;
            seconds_reg <= seconds_next;
            sub_reg     <= sub_next;
            lockout_reg <= lockout_next;
            mark_reg    <= mark_next;
            pulses_reg  <= pulses_next;
            times_reg   <= times_next;
            nums_reg    <= nums_next;
        end
    end

    for (genvar k = 0; k < LTWO_SLOTS; k++)
    begin : g_slot
        if (k < LAP_DEPTH)
        begin : g_used
            assign time_slot[k] = times_reg[k];
            assign num_slot[k]  = nums_reg[k];
        end
        else
        begin : g_empty
            assign time_slot[k] = '0;
            assign num_slot[k]  = '0;
        end
    end

    always_comb
    begin
        view.seconds = seconds_reg;
        view.pulses  = pulses_reg;
        for (int k = 0; k < LTWO_SLOTS; k++)
        begin
            view.lap_time[k] = time_slot[k];
            view.lap_num[k]  = num_slot[k];
        end
    end

endmodule

FILE: rtl/core/ltwo_speed.sv
// Average speed sequencer: scales distance and time, divides bit-serially.
module ltwo_speed (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                ack,
    input  logic [ltwo_pkg::LTWO_PULSE_W-1:0]   pulses,
    input  logic [ltwo_pkg::LTWO_SEC_W-1:0]     seconds,
    output logic                                busy,
    output logic                                valid,
    output logic [ltwo_pkg::LTWO_SPEED_W-1:0]   speed
);
    import ltwo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD1,
        S_DIV1,
        S_LOAD2,
        S_DIV2,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [LTWO_DVD_W-1:0]    m_reg;
    logic [LTWO_DIVR_W-1:0]   d_reg;
    logic [LTWO_SCALE_W-1:0]  x_reg;
    logic [LTWO_SPEED_W-1:0]  speed_reg;

    logic                     div_start;
    logic [LTWO_STEP_W-1:0]   div_steps;
    logic [LTWO_DVD_W-1:0]    div_dividend;
    logic [LTWO_DIVR_W-1:0]   div_divisor;
    logic                     div_done;
    logic [LTWO_DVD_W-1:0]    div_quotient;

    always_comb
    begin
        div_start    = (state_reg == S_LOAD1) || (state_reg == S_LOAD2);
        div_steps    = LTWO_STEP_W'(LTWO_DVD_W);
        div_dividend = m_reg;
        div_divisor  = d_reg;
        if (state_reg == S_LOAD2)
        begin
            div_steps    = LTWO_STEP_W'(LTWO_SCALE_W);
            div_dividend = {x_reg, (LTWO_DVD_W - LTWO_SCALE_W)'(0)};
            div_divisor  = LTWO_SPEED_DIV;
        end
    end

    ltwo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if ((pulses == '0) || (seconds == '0))
                        begin
                            speed_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            m_reg     <= LTWO_DVD_W'(pulses * LTWO_PULSE_SCALE);
                            d_reg     <= LTWO_DIVR_W'(seconds * LTWO_TIME_SCALE);
                            state_reg <= S_LOAD1;
                        end
                    end
                end
                S_LOAD1:
                begin
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        x_reg     <= LTWO_SCALE_W'(div_quotient[LTWO_SPEED_W-1:0]
                                                   * LTWO_SPEED_MUL);
                        state_reg <= S_LOAD2;
                    end
                end
                S_LOAD2:
                begin
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        speed_reg <= div_quotient[LTWO_SPEED_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (ack)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign valid = (state_reg == S_DONE);
    assign speed = speed_reg;

endmodule

FILE: tb/sv/lap_timer_with_odometer_unit_checker.sv
// Checker for the lap timer: predicts each result from the accepted items and compares.
`timescale 1ns / 100ps

module lap_timer_with_odometer_unit_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ltwo_pkg::LTWO_CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltwo_pkg::LTWO_CFG_DATA_W-1:0]  cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [ltwo_pkg::LTWO_IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [ltwo_pkg::LTWO_IN_USER_W-1:0]   s_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [ltwo_pkg::LTWO_OUT_DATA_W-1:0]  m_axis_tdata,
    output int                                    n_fail,
    output int                                    n_pending
);
    import ltwo_pkg::*;

    localparam int DEPTH = LTWO_LAP_DEPTH;
    localparam int MAX_REPORTS = 10;

    localparam logic [31:0] PULSE_SCALE = 32'd1548;
    localparam logic [31:0] TIME_SCALE  = 32'd20;
    localparam logic [31:0] KMH_MUL     = 32'd36;
    localparam logic [31:0] KMH_DIV     = 32'd1000;

    // packed from the top bit down, so elapsed sits in bits 15:0
    typedef struct packed {
        logic [15:0] avg_speed;
        logic [31:0] distance;
        logic [7:0]  lap_num_3;
        logic [7:0]  lap_num_2;
        logic [7:0]  lap_num_1;
        logic [15:0] lap_time_3;
        logic [15:0] lap_time_2;
        logic [15:0] lap_time_1;
        logic [15:0] elapsed;
    } lap_report_t;

    logic [LTWO_LOCK_W-1:0]  lock_reload;
    logic [LTWO_SUB_W-1:0]   tps;

    logic [LTWO_SEC_W-1:0]   secs;
    logic [LTWO_SUB_W-1:0]   sub_count;
    logic [LTWO_LOCK_W-1:0]  lock_left;
    logic [LTWO_SEC_W-1:0]   mark_sec;
    logic [LTWO_SEC_W-1:0]   lap_time_hist [DEPTH];
    logic [LTWO_NUM_W-1:0]   lap_num_hist [DEPTH];
    logic [LTWO_PULSE_W-1:0] pulse_count;
    logic                    run_active;

    lap_report_t expected_reports [$];
    int fail_count;

    function automatic logic [15:0] speed_of(logic [31:0] pulses, logic [15:0] elapsed);
        logic [31:0] scaled;
        logic [31:0] per_sec;
        logic [31:0] kmh;
        if (pulses == 0 || elapsed == 0)
            return 16'd0;
        scaled  = (pulses * PULSE_SCALE) / TIME_SCALE;
        per_sec = (scaled / {16'd0, elapsed}) & 32'h0000_FFFF;
        kmh     = per_sec * KMH_MUL / KMH_DIV;
        return kmh[15:0];
    endfunction

    task automatic clear_run();
        run_active  = 1'b0;
        secs        = '0;
        mark_sec    = '0;
        pulse_count = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            lap_time_hist[k] = '0;
            lap_num_hist[k]  = '0;
        end
    endtask

    task automatic mark_lap();
        lock_left = lock_reload;
        if (secs != mark_sec)
        begin
            for (int k = DEPTH - 1; k >= 1; k--)
                lap_time_hist[k] = lap_time_hist[k - 1];
            lap_time_hist[0] = secs - mark_sec;
            mark_sec = secs;
            for (int k = DEPTH - 1; k >= 2; k--)
                lap_num_hist[k] = lap_num_hist[k - 1];
            lap_num_hist[0] = lap_num_hist[0] + 8'd1;
            if (DEPTH > 1)
                lap_num_hist[1 % DEPTH] = lap_num_hist[0] - 8'd1;
        end
    endtask

    task automatic advance_state(logic [1:0] kind, logic sw, output lap_report_t rpt);
        case (kind)
            LTWO_REQ_TICK:
            begin
                if (run_active)
                    sub_count = sub_count + 1'b1;
                else if (sub_count < tps)
                    sub_count = sub_count + 1'b1;
                if (lock_left != 0)
                    lock_left = lock_left - 1'b1;
                else if (sw)
                    clear_run();
            end
            LTWO_REQ_LAP:
                mark_lap();
            LTWO_REQ_PULSE:
            begin
                run_active  = 1'b1;
                pulse_count = pulse_count + 1'b1;
            end
            default: ;
        endcase
        if (run_active && sub_count >= tps)
        begin
            secs      = secs + 1'b1;
            sub_count = '0;
        end
        rpt.elapsed    = secs;
        rpt.lap_time_1 = lap_time_hist[0];
        rpt.lap_time_2 = (DEPTH > 1) ? lap_time_hist[1 % DEPTH] : 16'd0;
        rpt.lap_time_3 = (DEPTH > 2) ? lap_time_hist[2 % DEPTH] : 16'd0;
        rpt.lap_num_1  = lap_num_hist[0];
        rpt.lap_num_2  = (DEPTH > 1) ? lap_num_hist[1 % DEPTH] : 8'd0;
        rpt.lap_num_3  = (DEPTH > 2) ? lap_num_hist[2 % DEPTH] : 8'd0;
        rpt.distance   = pulse_count;
        rpt.avg_speed  = speed_of(pulse_count, secs);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lap_report_t want;
        lap_report_t got;
        if (!rst_n)
        begin
            lock_reload = LTWO_LOCKOUT_RESET;
            tps         = LTWO_TPS_RESET;
            clear_run();
            sub_count   = '0;
            lock_left   = LTWO_LOCKOUT_RESET;
            expected_reports.delete();
            fail_count  = 0;
            n_fail    <= 0;
            n_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == LTWO_REG_LOCKOUT)
                    lock_reload = cfg_data[LTWO_LOCK_W-1:0];
                else if (cfg_index == LTWO_REG_TPS)
                    tps = cfg_data[LTWO_SUB_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_state(s_axis_tuser[1:0], s_axis_tdata[0], want);
                expected_reports.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = lap_report_t'(m_axis_tdata);
                if (expected_reports.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: result with nothing expected: %p", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.elapsed !== want.elapsed || got.lap_time_1 !== want.lap_time_1
                        || got.lap_time_2 !== want.lap_time_2
                        || got.lap_time_3 !== want.lap_time_3
                        || got.lap_num_1 !== want.lap_num_1 || got.lap_num_2 !== want.lap_num_2
                        || got.lap_num_3 !== want.lap_num_3 || got.distance !== want.distance
                        || got.avg_speed !== want.avg_speed)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", got);
                        end
                        fail_count++;
                    end
                end
            end
            n_fail    <= fail_count;
            n_pending <= expected_reports.size();
        end
    end

endmodule

FILE: tb/sv/lap_timer_with_odometer_unit_test.sv
// Top of the lap timer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module lap_timer_with_odometer_unit_test;

    import ltwo_pkg::*;

    localparam realtime CLK_PERIOD   = 10ns;
    localparam int      CYCLE_LIMIT  = 600000;
    localparam int      DRAIN_CYCLES = 80;
    localparam int      HOLD_CYCLES  = 500;
    localparam int      N_PHASES     = 5;
    localparam int      N_DIRECTED   = 18;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // negative values ask for a random setting
    localparam int PHASE_LOCKOUT [N_PHASES] = '{255, 0, -1, 3, -1};
    localparam int PHASE_TPS     [N_PHASES] = '{15, 1, -1, 10, -1};
    localparam int PHASE_ITEMS   [N_PHASES] = '{110, 150, 150, 140, 100};

    localparam logic [1:0] DIR_KIND [N_DIRECTED] = '{
        LTWO_REQ_TICK, LTWO_REQ_TICK, LTWO_REQ_TICK, LTWO_REQ_PULSE, LTWO_REQ_LAP,
        LTWO_REQ_LAP, LTWO_REQ_TICK, LTWO_REQ_TICK, REQ_UNUSED, LTWO_REQ_TICK,
        LTWO_REQ_LAP, LTWO_REQ_TICK, LTWO_REQ_TICK, LTWO_REQ_TICK, LTWO_REQ_PULSE,
        LTWO_REQ_TICK, LTWO_REQ_LAP, LTWO_REQ_LAP
    };
    localparam bit DIR_SW [N_DIRECTED] = '{
        0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 1, 1, 0, 0, 1, 0, 0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        cfg_we = 1'b0;
    logic [LTWO_CFG_IDX_W-1:0]   cfg_index = '0;
    logic [LTWO_CFG_DATA_W-1:0]  cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [LTWO_IN_DATA_W-1:0]   s_axis_tdata = '0;   // reset_switch
    logic [LTWO_IN_USER_W-1:0]   s_axis_tuser = '0;   // req_type
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // elapsed_sec, lap_time_1..3, lap_num_1..3, distance_pulses, avg_speed
    logic [LTWO_OUT_DATA_W-1:0]  m_axis_tdata;

    int n_fail;
    int n_pending;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lap_timer_with_odometer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lap_timer_with_odometer_unit_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .n_fail        (n_fail),
        .n_pending     (n_pending)
    );

    task automatic write_reg(logic [LTWO_CFG_IDX_W-1:0] idx, logic [LTWO_CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(logic [1:0] kind, logic sw);
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(LTWO_IN_DATA_W-1){1'b0}}, sw};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random_items(int count);
        int left;
        int burst;
        int gap;
        int pick;
        logic [1:0] kind;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            for (int i = 0; i < burst; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    kind = LTWO_REQ_TICK;
                else if (pick < 77)
                    kind = LTWO_REQ_PULSE;
                else if (pick < 97)
                    kind = LTWO_REQ_LAP;
                else
                    kind = REQ_UNUSED;
                send_item(kind, $urandom_range(0, 9) == 0);
            end
            left -= burst;
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 5);
                2: gap = $urandom_range(6, 30);
                default: gap = $urandom_range(31, 75);
            endcase
            if (gap > 0 || left == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: switch between stall patterns, with one long hold on request
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(64, 400);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("lap_timer_with_odometer_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        int lock_val;
        int tps_val;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short lockout so the switch is first ignored, then honored
        write_reg(LTWO_REG_LOCKOUT, 8'd1);
        write_reg(LTWO_REG_TPS, 8'd2);
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIR_KIND[i], DIR_SW[i]);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int p = 0; p < N_PHASES; p++)
        begin
            lock_val = (PHASE_LOCKOUT[p] < 0) ? $urandom_range(0, 255) : PHASE_LOCKOUT[p];
            tps_val  = (PHASE_TPS[p] < 0) ? $urandom_range(1, 15) : PHASE_TPS[p];
            write_reg(LTWO_REG_LOCKOUT, lock_val[7:0]);
            // upper bits of the tps write are don't-care
            write_reg(LTWO_REG_TPS, {4'($urandom_range(0, 15)), tps_val[3:0]});
            if (p == 2)
                hold_request = 1'b1;
            send_random_items(PHASE_ITEMS[p]);
            wait_drained();
        end

        if (n_fail == 0 && n_pending == 0)
            $display("lap_timer_with_odometer_unit_test OK");
        else
            $display("lap_timer_with_odometer_unit_test NOT OK");
        $finish;
    end

endmodule
